// ----- hw/rtl/pqte_pkg.sv -----
`timescale 1ns / 1ps

package pqte_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 17;
  localparam int DATA_W   = 32;
  localparam int CODE_W   = 16;
  localparam int BUCKET_W = 16;
  localparam int PEAK_W   = 31;

  localparam int BUCKET_SHIFT_DEF  = 16;
  localparam int SEARCH_WINDOW_DEF = 8;
  localparam int CODE_COUNT_DEF    = 65536;

  localparam logic [CMD_W-1:0] CMD_ENCODE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_THRESH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_BUCKET = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_THRESH = 2'd3;

  localparam logic [PEAK_W-1:0] PEAK_RESET   = 31'h461C_4000;
  localparam logic [DATA_W-1:0] POS_INF_BITS = 32'h7F80_0000;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] threshold_bits;
  } result_t;

endpackage

// ----- hw/rtl/pqte_ram.sv -----
`timescale 1ns / 1ps

module pqte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pq_code_threshold_encoder_unit.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// item      item_valid / item_stall    pqte_pkg::item_t (command, index, value)
// result    result_valid / result_stall pqte_pkg::result_t (code, threshold_bits)
// cfg       cfg_valid / cfg_ready      cfg_data (peak luminance float bits)
//
// An encode that needs the tables holds off the next item until its result is loaded:
// one bucket read, then one threshold read per window entry on the single read port of
// the threshold memory, then a sum step and a step that loads the output. Threshold
// reads and encodes of zero, negative, NaN or peak inputs also hold off the next item
// until their result is loaded; writes finish when accepted. Reset restores the peak
// register and leaves the tables unwritten. A stalled result holds in the output register;
// the next item is still accepted and waits for that register only when it has a result of its own.

module pq_code_threshold_encoder_unit #(
  parameter int BUCKET_SHIFT  = pqte_pkg::BUCKET_SHIFT_DEF,
  parameter int SEARCH_WINDOW = pqte_pkg::SEARCH_WINDOW_DEF,
  parameter int CODE_COUNT    = pqte_pkg::CODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  pqte_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pqte_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pqte_pkg::PEAK_W-1:0]   cfg_data
);

  import pqte_pkg::*;

  localparam int THRESH_DEPTH = CODE_COUNT + SEARCH_WINDOW;
  localparam int TAW          = $clog2(THRESH_DEPTH);
  localparam int BUCKET_DEPTH = (1 << (31 - BUCKET_SHIFT)) + 1;
  localparam int BAW          = $clog2(BUCKET_DEPTH);
  localparam int KW           = $clog2(SEARCH_WINDOW + 1);

  localparam logic [INDEX_W-1:0] THRESH_LIMIT = INDEX_W'(THRESH_DEPTH);
  localparam logic [INDEX_W-1:0] CODE_MAX     = INDEX_W'(CODE_COUNT - 1);
  localparam logic [KW-1:0]      WIN_LAST     = KW'(SEARCH_WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BKT  = 3'd1;
  localparam logic [2:0] S_WIN  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state;
  logic [PEAK_W-1:0]   max_peak;
  logic [DATA_W-1:0]   val;
  logic [BUCKET_W-1:0] first;
  logic [KW-1:0]       issue_k;
  logic [KW-1:0]       passed;
  logic                pend;
  logic                pend_ok;
  logic [CODE_W-1:0]   res_code;
  logic [DATA_W-1:0]   res_thr;

  logic                accept;
  logic                zero_class;
  logic                peak_hit;
  logic [BUCKET_W-1:0] win_base;
  logic [KW-1:0]       win_off;
  logic [INDEX_W-1:0]  win_idx;
  logic                win_ok;
  logic                issue_win;
  logic                hit;
  logic [INDEX_W-1:0]  rd_idx;
  logic                rd_ok;
  logic [INDEX_W-1:0]  total;
  logic [CODE_W-1:0]   sat_code;

  logic                thr_wr_en;
  logic                thr_rd_en;
  logic [TAW-1:0]      thr_rd_addr;
  logic [DATA_W-1:0]   thr_rdata;
  logic                bkt_wr_en;
  logic                bkt_rd_en;
  logic [BUCKET_W-1:0] bkt_rdata;

  // Nothing is taken in while reset is held.
  assign item_stall = rst | (state != S_IDLE);
  assign cfg_ready  = ~rst;
  assign accept     = item_valid & ~item_stall;

  assign zero_class = item.value[31] | (item.value == '0) | (item.value > POS_INF_BITS);
  assign peak_hit   = ({1'b0, max_peak} <= POS_INF_BITS) && (item.value[30:0] >= max_peak);

  // The first window read is issued straight from the bucket data, later ones from first.
  assign win_base  = (state == S_BKT) ? bkt_rdata : first;
  assign win_off   = (state == S_BKT) ? '0 : issue_k;
  assign win_idx   = INDEX_W'(win_base) + INDEX_W'(win_off);
  assign win_ok    = (win_idx < THRESH_LIMIT);
  assign issue_win = (state == S_BKT) || ((state == S_WIN) && (issue_k < WIN_LAST));
  assign hit       = pend & pend_ok & (thr_rdata <= val);

  assign rd_idx = item.index - INDEX_W'(1);
  assign rd_ok  = (item.index != '0) && (rd_idx < THRESH_LIMIT);

  assign total    = INDEX_W'(first) + INDEX_W'(passed);
  assign sat_code = (total > CODE_MAX) ? CODE_MAX[CODE_W-1:0] : total[CODE_W-1:0];

  assign thr_wr_en   = accept && (item.command == CMD_WR_THRESH) && (item.index < THRESH_LIMIT);
  assign thr_rd_en   = (accept && (item.command == CMD_RD_THRESH) && rd_ok) || issue_win;
  assign thr_rd_addr = (state == S_IDLE) ? TAW'(rd_idx) : TAW'(win_idx);

  assign bkt_wr_en = accept && (item.command == CMD_WR_BUCKET) &&
                     (32'(item.index) < 32'(BUCKET_DEPTH));
  assign bkt_rd_en = accept && (item.command == CMD_ENCODE);

  pqte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (THRESH_DEPTH)
  ) u_thresh_ram (
    .clk     (clk),
    .wr_en   (thr_wr_en),
    .wr_addr (TAW'(item.index)),
    .wr_data (item.value),
    .rd_en   (thr_rd_en),
    .rd_addr (thr_rd_addr),
    .rd_data (thr_rdata)
  );

  pqte_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (BUCKET_DEPTH)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (bkt_wr_en),
    .wr_addr (BAW'(item.index)),
    .wr_data (item.value[BUCKET_W-1:0]),
    .rd_en   (bkt_rd_en),
    .rd_addr (BAW'(item.value[30:BUCKET_SHIFT])),
    .rd_data (bkt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pend         <= 1'b0;
      max_peak     <= PEAK_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_peak <= cfg_data;
      end
      // The final state reloads the output register itself when the slot frees up.
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.command)
              CMD_ENCODE: begin
                val      <= item.value;
                res_thr  <= '0;
                if (zero_class) begin
                  res_code <= '0;
                  state    <= S_DONE;
                end else if (peak_hit) begin
                  res_code <= CODE_MAX[CODE_W-1:0];
                  state    <= S_DONE;
                end else begin
                  state <= S_BKT;
                end
              end
              CMD_RD_THRESH: begin
                res_code <= '0;
                res_thr  <= '0;
                state    <= rd_ok ? S_RD : S_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        S_BKT: begin
          first   <= bkt_rdata;
          issue_k <= KW'(1);
          passed  <= '0;
          pend    <= 1'b1;
          pend_ok <= win_ok;
          state   <= S_WIN;
        end
        S_WIN: begin
          passed <= passed + KW'(hit);
          if (issue_win) begin
            pend    <= 1'b1;
            pend_ok <= win_ok;
            issue_k <= issue_k + KW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          res_code <= sat_code;
          state    <= S_DONE;
        end
        S_RD: begin
          res_thr <= thr_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid          <= 1'b1;
            result.code           <= res_code;
            result.threshold_bits <= res_thr;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new result is loaded only from the final state of an item.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the final state");

  // Write commands finish in the cycle they are accepted.
  a_write_single_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (item.command == CMD_WR_THRESH || item.command == CMD_WR_BUCKET)
    |=> state == S_IDLE)
    else $error("write command did not return to idle");

  // The window never issues or counts past its size.
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WIN || state == S_SUM) |-> (issue_k <= WIN_LAST && passed <= WIN_LAST))
    else $error("window counter out of range");

  // An encode result carries no threshold, a read result carries no code.
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.code == '0 || result.threshold_bits == '0))
    else $error("result has both code and threshold set");

endmodule
